### hw/rtl/tmcm_pkg.sv
// Package for the transform matrix column multiply block.
// Holds the shared constants, transaction types and operation codes.
// No dependencies.
package tmcm_pkg;

    // Default sizing
    localparam int DIM_DEFAULT       = 4;
    localparam int FRAC_BITS_DEFAULT = 16;

    // Fixed field sizes
    localparam int NIN       = 4;
    localparam int NIN_W     = $clog2(NIN);
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;

    // Queue depths
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef logic signed [DATA_W-1:0] word_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MUL  = 1'b1
    } op_t;

    // Input transaction
    typedef struct packed {
        logic       kind;
        logic [1:0] col_index;
        word_t      in0;
        word_t      in1;
        word_t      in2;
        word_t      in3;
        logic       commit;
    } item_t;

    // Result transaction
    typedef struct packed {
        logic [1:0] out_col;
        word_t      out0;
        word_t      out1;
        word_t      out2;
        word_t      out3;
        logic       saturated;
    } result_t;

    // Classified command between front and back
    typedef struct packed {
        op_t              op;
        logic [1:0]       col;
        logic             col_ok;
        logic             commit;
        word_t [NIN-1:0]  v;
    } cmd_t;

endpackage

### hw/rtl/tmcm_queue.sv
// Small synchronous FIFO used for the command and result queues.
// Depends on nothing; width and depth come in as parameters.
module tmcm_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         pop,
    input  logic [WIDTH-1:0]             wdata,
    output logic [WIDTH-1:0]             rdata,
    output logic                         full,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    // Status
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = rdata_reg;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage and registered head word; a word written into the next head slot bypasses
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
        if (do_push && (wr_ptr_reg == rd_ptr_next))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[rd_ptr_next];
        end
    end

endmodule

### hw/rtl/tmcm_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on tmcm_pkg and tmcm_queue.
module tmcm_front
    import tmcm_pkg::*;
#(
    parameter int DIM = DIM_DEFAULT
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t item,
    input  logic  cmd_pop,
    output cmd_t  cmd,
    output logic  cmd_empty
);

    cmd_t                   cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_raw;

    // Decode the transaction into a command
    always_comb
    begin
        cmd_in.op     = op_t'(item.kind);
        cmd_in.col    = item.col_index;
        cmd_in.col_ok = (int'(item.col_index) < DIM);
        cmd_in.commit = item.commit;
        cmd_in.v[0]   = item.in0;
        cmd_in.v[1]   = item.in1;
        cmd_in.v[2]   = item.in2;
        cmd_in.v[3]   = item.in3;
    end

    // Command queue toward the back end
    tmcm_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (cmd_pop),
        .wdata (cmd_in),
        .rdata (cmd_raw),
        .full  (full),
        .empty (cmd_empty),
        .count ()
    );

    assign cmd = cmd_t'(cmd_raw);

endmodule

### hw/rtl/tmcm_back.sv
// Back end: holds the current and pending matrices, multiplies, sums and clips.
// Depends on tmcm_pkg.
module tmcm_back
    import tmcm_pkg::*;
#(
    parameter int DIM       = DIM_DEFAULT,
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic                 cmd_empty,
    output logic                 cmd_pop,
    input  logic [RES_CNT_W-1:0] res_count,
    output logic                 res_push,
    output result_t              res_data
);

    localparam int    NV    = (DIM < NIN) ? DIM : NIN;
    localparam int    NE    = DIM * DIM;
    localparam int    SUM_W = PROD_W + $clog2(NV);
    localparam word_t ONE_Q = word_t'(1 << FRAC_BITS);
    localparam word_t MAX_W = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t MIN_W = {1'b1, {(DATA_W-1){1'b0}}};

    // Matrix state, element (r, c) at r + c*DIM
    word_t m_reg [NE];
    word_t m_next [NE];
    word_t p_reg [NE];
    word_t p_next [NE];
    word_t pnew_b [NE];

    // Multiply stage registers
    logic                      b_valid_reg;
    op_t                       b_op_reg;
    logic [1:0]                b_col_reg;
    logic                      b_col_ok_reg;
    logic                      b_commit_reg;
    word_t [NIN-1:0]           b_v_reg;
    logic signed [PROD_W-1:0]  prod_reg  [DIM][NV];
    logic signed [PROD_W-1:0]  prod_next [DIM][NV];

    // Combinational intermediates
    word_t                     vx [DIM];
    logic signed [SUM_W-1:0]   row_sum [DIM];
    logic signed [SUM_W-1:0]   row_shift [DIM];
    word_t                     row_val [DIM];
    logic [DIM-1:0]            row_ovf;
    word_t                     res_w [NIN];
    logic                      hazard, room, issue, b_mul, x_load, x_hit, b_hit;
    logic [RES_CNT_W:0]        used;

    // Issue control: stall on a commit next to a multiply, or no result room
    always_comb
    begin
        b_mul   = b_valid_reg && (b_op_reg == OP_MUL);
        hazard  = b_mul && (b_commit_reg || cmd.commit);
        used    = {1'b0, res_count} + (RES_CNT_W+1)'(b_valid_reg);
        room    = (used < (RES_CNT_W+1)'(RES_DEPTH));
        issue   = !cmd_empty && !hazard && room;
        cmd_pop = issue;
        x_load  = issue && (cmd.op == OP_LOAD) && cmd.col_ok;
    end

    // Operand column, rows past the input width read as zero
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            vx[r] = '0;
        end
        for (int r = 0; r < NV; r++)
        begin
            vx[r] = cmd.v[NIN_W'(r)];
        end
    end

    // Products of M and the column
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            for (int i = 0; i < NV; i++)
            begin
                prod_next[r][i] = m_reg[r + i * DIM] * vx[i];
            end
        end
    end

    // Row sums, floor shift and clip
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            row_sum[r] = '0;
            for (int i = 0; i < NV; i++)
            begin
                row_sum[r] = row_sum[r] + SUM_W'(prod_reg[r][i]);
            end
            row_shift[r] = row_sum[r] >>> FRAC_BITS;
            row_ovf[r]   = !((&row_shift[r][SUM_W-1:DATA_W-1]) ||
                             !(|row_shift[r][SUM_W-1:DATA_W-1]));
            if (row_ovf[r])
            begin
                row_val[r] = row_shift[r][SUM_W-1] ? MIN_W : MAX_W;
            end
            else
            begin
                row_val[r] = row_shift[r][DATA_W-1:0];
            end
        end
    end

    // Result transaction
    always_comb
    begin
        for (int r = 0; r < NIN; r++)
        begin
            res_w[r] = '0;
        end
        for (int r = 0; r < NV; r++)
        begin
            res_w[r] = (b_op_reg == OP_MUL) ? row_val[r] : b_v_reg[NIN_W'(r)];
        end
        res_push            = b_valid_reg;
        res_data.out_col    = b_col_reg;
        res_data.out0       = res_w[0];
        res_data.out1       = res_w[1];
        res_data.out2       = res_w[2];
        res_data.out3       = res_w[3];
        res_data.saturated  = (b_op_reg == OP_MUL) && (|row_ovf);
    end

    // Matrix updates: finishing multiply first, then the issuing item
    always_comb
    begin
        for (int c = 0; c < DIM; c++)
        begin
            b_hit = b_col_ok_reg && (int'(b_col_reg) == c);
            x_hit = x_load && (int'(cmd.col) == c);
            for (int r = 0; r < DIM; r++)
            begin
                pnew_b[r + c * DIM] = b_hit ? row_val[r] : p_reg[r + c * DIM];
                p_next[r + c * DIM] = b_mul ? pnew_b[r + c * DIM] : p_reg[r + c * DIM];
                m_next[r + c * DIM] = m_reg[r + c * DIM];
                if (b_mul && b_commit_reg)
                begin
                    m_next[r + c * DIM] = pnew_b[r + c * DIM];
                end
                if (x_hit)
                begin
                    p_next[r + c * DIM] = vx[r];
                    m_next[r + c * DIM] = vx[r];
                end
                if (issue && (cmd.op == OP_LOAD) && cmd.commit)
                begin
                    m_next[r + c * DIM] = p_next[r + c * DIM];
                end
            end
        end
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            for (int c = 0; c < DIM; c++)
            begin
                for (int r = 0; r < DIM; r++)
                begin
                    m_reg[r + c * DIM] <= (r == c) ? ONE_Q : '0;
                    p_reg[r + c * DIM] <= (r == c) ? ONE_Q : '0;
                end
            end
        end
        else
        begin
            b_valid_reg <= issue;
            for (int k = 0; k < NE; k++)
            begin
                m_reg[k] <= m_next[k];
                p_reg[k] <= p_next[k];
            end
        end
    end

    // Multiply stage payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_op_reg     <= cmd.op;
            b_col_reg    <= cmd.col;
            b_col_ok_reg <= cmd.col_ok;
            b_commit_reg <= cmd.commit;
            b_v_reg      <= cmd.v;
            prod_reg     <= prod_next;
        end
    end

endmodule

### hw/rtl/transform_matrix_column_multiply.sv
// Top level of the transform matrix column multiply block.
// Depends on tmcm_pkg, tmcm_front, tmcm_back and tmcm_queue.
//
//  channel   handshake            payload     accepted when
//  input     push / full          item        push && !full
//  result    empty / pop          result      pop && !empty
//
// One transaction per cycle sustained while no commit hazard or full result queue
// stalls issue; a result passes through the command queue read, the registered
// product stage and the result queue. The item after a multiply that commits,
// and a committing item right after any multiply, waits for the pending column to be written.
// Reset sets both matrices to identity at once; no sweep is needed.
// A full result queue stalls issue; the command queue then fills and raises full.
module transform_matrix_column_multiply
    import tmcm_pkg::*;
#(
    parameter int DIM       = DIM_DEFAULT,
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    cmd_t                       cmd;
    logic                       cmd_empty, cmd_pop;
    logic [RES_CNT_W-1:0]       res_count;
    logic                       res_push;
    result_t                    res_data;
    logic [$bits(result_t)-1:0] res_raw;

    tmcm_front #(
        .DIM (DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_empty (cmd_empty)
    );

    tmcm_back #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_count (res_count),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // Result queue
    tmcm_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .pop   (pop),
        .wdata (res_data),
        .rdata (res_raw),
        .full  (),
        .empty (empty),
        .count (res_count)
    );

    assign result = result_t'(res_raw);

endmodule

### hw/rtl/tmcm_checker.sv
// Port-level checker for the transform matrix column multiply block.
// Depends on tmcm_pkg; bound to the top level at the end of this file.
module tmcm_checker
    import tmcm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    push,
    input logic    full,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    logic [3:0] pending_reg;

    // Transactions accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 4'(push && !full) - 4'(pop && !empty);
        end
    end

    // No result without an accepted input
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty) |-> (pending_reg != '0))
        else $error("result delivered with nothing outstanding");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == '0) |-> empty)
        else $error("result shown with nothing outstanding");

    // Full only rises after a push
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

    // A waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

endmodule

bind transform_matrix_column_multiply tmcm_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

### bench/tb_transform_matrix_column_multiply.sv
// Testbench for transform_matrix_column_multiply: directed and random column streams,
// checked against an in-bench Q16.16 matrix model with saturation.
// Depends on tmcm_pkg and the transform_matrix_column_multiply RTL.
`timescale 1ns / 1ps

module tb_transform_matrix_column_multiply;
    import tmcm_pkg::*;

    localparam int    ACC_W          = PROD_W + 4;
    localparam int    RANDOM_ITEMS   = 1500;
    localparam int    LONG_HOLD      = 300;
    localparam int    WATCHDOG_LIMIT = 4000;
    localparam int    DRAIN_CYCLES   = 8;
    localparam int    MAX_REPORTS    = 20;
    localparam word_t W_MAX          = 32'sh7FFF_FFFF;
    localparam word_t W_MIN          = 32'sh8000_0000;
    localparam word_t W_ONE          = 32'sh0001_0000;
    localparam logic signed [ACC_W-1:0] SUM_MAX = 68'sh7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SUM_MIN = -68'sh8000_0000;

    typedef enum int { RX_STREAM, RX_RANDOM, RX_PATTERN } rx_mode_t;
    typedef enum int { SEQ_LOAD_MATRIX, SEQ_VERTICES, SEQ_COMPOSE, SEQ_PARTIAL, SEQ_NOISE } seq_t;

    logic    clk    = 1'b0;
    logic    rst_n  = 1'b0;
    logic    push   = 1'b0;
    logic    pop    = 1'b0;
    item_t   item   = '0;
    logic    full;
    logic    empty;
    result_t result;

    // Model state: current transform and pending product, element (r, c) at r + c*DIM
    word_t   xform_mat   [DIM_DEFAULT*DIM_DEFAULT];
    word_t   pending_mat [DIM_DEFAULT*DIM_DEFAULT];
    result_t expected_cols [$];

    int      mismatches    = 0;
    int      items_sent    = 0;
    int      results_seen  = 0;
    int      loads_seen    = 0;
    int      muls_seen     = 0;
    int      commits_seen  = 0;
    int      sat_seen      = 0;
    int      full_stalls   = 0;
    int      idle_cycles   = 0;
    int      burst_left    = 0;
    bit      gaps_on       = 1'b1;
    logic    long_hold_req = 1'b0;
    logic    long_hold_ack = 1'b0;
    int      hold_left     = 0;
    int      mode_left     = 0;
    int      rx_phase      = 0;
    rx_mode_t rx_mode      = RX_STREAM;

    transform_matrix_column_multiply dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #10 clk = ~clk;

    // Column transform: load echoes and writes both stores, multiply forms M * v
    function automatic result_t transform_column(item_t it);
        result_t r;
        word_t   v       [DIM_DEFAULT];
        word_t   col_out [DIM_DEFAULT];
        logic signed [ACC_W-1:0] acc;
        int      c;
        r       = '0;
        v[0]    = it.in0;
        v[1]    = it.in1;
        v[2]    = it.in2;
        v[3]    = it.in3;
        c       = int'(it.col_index);
        r.out_col = it.col_index;
        if (op_t'(it.kind) == OP_LOAD) begin
            for (int row = 0; row < DIM_DEFAULT; row++) begin
                col_out[row] = v[row];
                xform_mat[row + c*DIM_DEFAULT]   = v[row];
                pending_mat[row + c*DIM_DEFAULT] = v[row];
            end
        end else begin
            for (int row = 0; row < DIM_DEFAULT; row++) begin
                acc = '0;
                for (int k = 0; k < DIM_DEFAULT; k++)
                    acc = acc + xform_mat[row + k*DIM_DEFAULT] * v[k];
                // arithmetic shift drops low bits toward minus infinity
                acc = acc >>> FRAC_BITS_DEFAULT;
                if (acc > SUM_MAX) begin
                    col_out[row] = W_MAX;
                    r.saturated  = 1'b1;
                end else if (acc < SUM_MIN) begin
                    col_out[row] = W_MIN;
                    r.saturated  = 1'b1;
                end else begin
                    col_out[row] = acc[DATA_W-1:0];
                end
            end
            for (int row = 0; row < DIM_DEFAULT; row++)
                pending_mat[row + c*DIM_DEFAULT] = col_out[row];
        end
        if (it.commit)
            xform_mat = pending_mat;
        r.out0 = col_out[0];
        r.out1 = col_out[1];
        r.out2 = col_out[2];
        r.out3 = col_out[3];
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, name, exp_v, act_v);
        end
    endfunction

    function automatic item_t column_item(op_t op, logic [1:0] col, word_t a, word_t b,
                                          word_t c, word_t d, logic commit);
        item_t it;
        it.kind      = op;
        it.col_index = col;
        it.in0       = a;
        it.in1       = b;
        it.in2       = c;
        it.in3       = d;
        it.commit    = commit;
        return it;
    endfunction

    // Mostly small Q16.16 values, with medium, full-range and extreme ones mixed in
    function automatic word_t rand_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return word_t'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
            5, 6:          return word_t'($urandom_range(0, 32'h200_0000)) - 32'sh100_0000;
            7, 8:          return word_t'($urandom);
            default:
                case ($urandom_range(0, 5))
                    0:       return W_MAX;
                    1:       return W_MIN;
                    2:       return '0;
                    3:       return -32'sd1;
                    4:       return W_ONE;
                    default: return -W_ONE;
                endcase
        endcase
    endfunction

    // Offer one transaction, with burst/gap idling, and hold until it is taken
    task automatic send_item(input item_t it);
        if (burst_left == 0) begin
            if (gaps_on) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
        items_sent++;
    endtask

    // Input and result monitor: predict on acceptance, check in order
    always @(posedge clk) begin : monitor
        result_t exp_r;
        if (rst_n) begin
            if (push && full)
                full_stalls++;
            if (push && !full) begin
                expected_cols.push_back(transform_column(item));
                if (op_t'(item.kind) == OP_LOAD) loads_seen++;
                else                             muls_seen++;
                if (item.commit) commits_seen++;
            end
            if (pop && !empty) begin
                results_seen++;
                if (result.saturated) sat_seen++;
                if (expected_cols.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t ns: unexpected result, expected none, actual %h",
                                 $time, result);
                end else begin
                    exp_r = expected_cols.pop_front();
                    check_field("out_col",   32'(exp_r.out_col),   32'(result.out_col));
                    check_field("out0",      exp_r.out0,           result.out0);
                    check_field("out1",      exp_r.out1,           result.out1);
                    check_field("out2",      exp_r.out2,           result.out2);
                    check_field("out3",      exp_r.out3,           result.out3);
                    check_field("saturated", 32'(exp_r.saturated), 32'(result.saturated));
                end
            end
        end
    end

    // Result side: long hold on request, otherwise rotating stall modes
    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else if (long_hold_req != long_hold_ack) begin
            long_hold_ack <= long_hold_req;
            hold_left     <= LONG_HOLD;
            pop           <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end else begin
            rx_phase <= rx_phase + 1;
            if (mode_left == 0) begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 2));
                mode_left <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_STREAM:  pop <= 1'b1;
                RX_RANDOM:  pop <= 1'($urandom_range(0, 1));
                default:    pop <= (rx_phase % 7) < 3;
            endcase
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("%0t ns: watchdog expired with %0d results outstanding",
                         $time, expected_cols.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Identity after reset: M * v returns v
    task automatic test_identity_multiply();
        send_item(column_item(OP_MUL, 2'd0, W_MAX, W_MIN, '0, -32'sd1, 1'b0));
        send_item(column_item(OP_MUL, 2'd3, W_ONE, -W_ONE, 32'sd12345, -32'sd7, 1'b0));
    endtask

    // Loads echo the column and set up a matrix with extreme entries
    task automatic test_load_echo();
        send_item(column_item(OP_LOAD, 2'd0, W_MAX, W_MAX, W_MIN, W_MIN, 1'b0));
        send_item(column_item(OP_LOAD, 2'd1, W_MAX, W_MIN, W_MAX, W_MIN, 1'b0));
        send_item(column_item(OP_LOAD, 2'd2, 32'sd1, -32'sd1, '0, W_ONE, 1'b0));
        send_item(column_item(OP_LOAD, 2'd3, '0, '0, '0, '0, 1'b0));
    endtask

    // Sums beyond the 32-bit range clip both ways
    task automatic test_saturation();
        send_item(column_item(OP_MUL, 2'd0, W_MAX, W_MAX, '0, '0, 1'b0));
        send_item(column_item(OP_MUL, 2'd0, W_MIN, W_MIN, '0, '0, 1'b0));
        send_item(column_item(OP_MUL, 2'd1, W_MIN, W_MAX, W_MAX, W_MIN, 1'b0));
    endtask

    // Tiny negative products round toward minus infinity
    task automatic test_truncation();
        send_item(column_item(OP_MUL, 2'd2, '0, '0, -32'sd1, '0, 1'b0));
        send_item(column_item(OP_MUL, 2'd2, '0, '0, 32'sd1, '0, 1'b0));
    endtask

    // Commit back to back with multiplies, partial commit, commit on a load
    task automatic test_commit_ordering();
        gaps_on = 1'b0;
        send_item(column_item(OP_MUL, 2'd1, W_ONE, W_ONE, W_ONE, W_ONE, 1'b1));
        send_item(column_item(OP_MUL, 2'd2, W_ONE, '0, -W_ONE, 32'sd3, 1'b0));
        send_item(column_item(OP_LOAD, 2'd0, W_ONE, '0, '0, '0, 1'b1));
        send_item(column_item(OP_MUL, 2'd3, 32'sd2, 32'sd300, -32'sd5, W_ONE, 1'b1));
        send_item(column_item(OP_MUL, 2'd0, W_ONE, W_ONE, W_ONE, W_ONE, 1'b0));
        send_item(column_item(OP_LOAD, 2'd3, W_ONE, W_ONE, W_ONE, W_ONE, 1'b1));
        gaps_on = 1'b1;
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_result_backpressure();
        gaps_on = 1'b0;
        long_hold_req <= ~long_hold_req;
        for (int n = 0; n < 40; n++)
            send_item(column_item(op_t'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                  rand_word(), rand_word(), rand_word(), rand_word(),
                                  1'($urandom_range(0, 7) == 0)));
        gaps_on = 1'b1;
    endtask

    // Random mix of matrix loads, vertex streams, compositions and noise
    task automatic test_random_streams();
        int   goal;
        int   n;
        int   base;
        seq_t seq;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            gaps_on = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 19))
                0, 1, 2, 3:                  seq = SEQ_LOAD_MATRIX;
                4, 5, 6, 7, 8, 9, 10:        seq = SEQ_VERTICES;
                11, 12, 13, 14:              seq = SEQ_COMPOSE;
                15, 16:                      seq = SEQ_PARTIAL;
                default:                     seq = SEQ_NOISE;
            endcase
            case (seq)
                SEQ_LOAD_MATRIX: begin
                    base = $urandom_range(0, 3);
                    for (int k = 0; k < 4; k++)
                        send_item(column_item(OP_LOAD, 2'(base + k), rand_word(), rand_word(),
                                              rand_word(), rand_word(),
                                              k == 3 && $urandom_range(0, 1) == 1));
                end
                SEQ_VERTICES: begin
                    n = $urandom_range(1, 16);
                    for (int k = 0; k < n; k++)
                        send_item(column_item(OP_MUL, 2'($urandom_range(0, 3)), rand_word(),
                                              rand_word(), rand_word(), rand_word(), 1'b0));
                end
                SEQ_COMPOSE: begin
                    for (int k = 0; k < 4; k++)
                        send_item(column_item(OP_MUL, 2'(k), rand_word(), rand_word(),
                                              rand_word(), rand_word(), k == 3));
                end
                SEQ_PARTIAL: begin
                    n = $urandom_range(1, 3);
                    for (int k = 0; k < n; k++)
                        send_item(column_item(OP_MUL, 2'($urandom_range(0, 3)), rand_word(),
                                              rand_word(), rand_word(), rand_word(), k == n - 1));
                end
                default: begin
                    send_item(column_item(op_t'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                          word_t'($urandom), word_t'($urandom),
                                          word_t'($urandom), word_t'($urandom),
                                          1'($urandom_range(0, 1))));
                end
            endcase
        end
    endtask

    initial begin
        for (int i = 0; i < DIM_DEFAULT*DIM_DEFAULT; i++) begin
            xform_mat[i]   = (i % (DIM_DEFAULT + 1) == 0) ? W_ONE : '0;
            pending_mat[i] = xform_mat[i];
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_identity_multiply();
        test_load_echo();
        test_saturation();
        test_truncation();
        test_commit_ordering();
        test_result_backpressure();
        test_random_streams();
        push <= 1'b0;

        // Drain outstanding results, then allow the pipeline to settle
        while (expected_cols.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d columns: %0d loads, %0d multiplies, %0d with commit.",
                 items_sent, loads_seen, muls_seen, commits_seen);
        $display("Checked %0d results, %0d saturated; input stalled by full for %0d cycles.",
                 results_seen, sat_seen, full_stalls);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
hw/rtl/tmcm_pkg.sv
hw/rtl/tmcm_queue.sv
hw/rtl/tmcm_front.sv
hw/rtl/tmcm_back.sv
hw/rtl/transform_matrix_column_multiply.sv
hw/rtl/tmcm_checker.sv
bench/tb_transform_matrix_column_multiply.sv
